[hw/rtl/trial_division_prime_test_defines.svh]
// Assertion macros for the trial division prime test block
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TDPT_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("tdpt: same-cycle check failed");
`define TDPT_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("tdpt: next-cycle check failed");
`else
`define TDPT_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define TDPT_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

[hw/rtl/tdpt_pkg.sv]
// Shared constants and types for the trial division prime test block
`timescale 1ns / 1ps
package tdpt_pkg;
  localparam int IN_W       = 16;
  localparam int WIDTH      = 16;
  localparam int DIV_W      = WIDTH / 2 + 2;
  localparam int SQ_W       = WIDTH + 2;
  localparam int OUT_W      = 8;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(WIDTH + 1);

  localparam logic [WIDTH-1:0] VALUE_TWO   = WIDTH'(2);
  localparam logic [DIV_W-1:0] FIRST_DIV   = DIV_W'(3);
  localparam logic [SQ_W-1:0]  FIRST_SQ    = SQ_W'(9);
  localparam logic [DIV_W-1:0] DIV_STEP    = DIV_W'(2);
  localparam logic [SQ_W-1:0]  SQ_STEP_ADD = SQ_W'(4);

  typedef struct packed {
    logic [WIDTH-1:0] value;
    logic             trivial;
    logic             trivial_prime;
  } queue_entry_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
  } div_status_t;
endpackage

[hw/rtl/tdpt_front.sv]
// Input side: accept beats and sort out values that need no division
`timescale 1ns / 1ps
module tdpt_front (
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [tdpt_pkg::IN_W-1:0] s_tdata,  // [15:0] value
  input  logic                  full,
  output logic                  push,
  output tdpt_pkg::queue_entry_t entry
);
  import tdpt_pkg::*;

  logic [WIDTH-1:0] v;

  assign v        = s_tdata[WIDTH-1:0];
  assign s_tready = !full;
  assign push     = s_tvalid && !full;

  always_comb begin
    entry.value         = v;
    entry.trivial       = !v[0] || (v[WIDTH-1:1] == '0);
    entry.trivial_prime = (v == VALUE_TWO);
  end
endmodule

[hw/rtl/tdpt_fifo.sv]
// Short queue between the input side and the division engine
`timescale 1ns / 1ps
module tdpt_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  tdpt_pkg::queue_entry_t wr_entry,
  input  logic                   pop,
  output tdpt_pkg::queue_entry_t rd_entry,
  output logic                   full,
  output logic                   empty
);
  import tdpt_pkg::*;

  queue_entry_t           slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_ptr;
  logic [FIFO_AW-1:0]     rd_ptr;
  logic [FIFO_AW:0]       count;

  assign full     = (count == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

[hw/rtl/tdpt_div.sv]
// Bit-serial restoring remainder unit
`timescale 1ns / 1ps
module tdpt_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tdpt_pkg::WIDTH-1:0] dividend,
  input  logic [tdpt_pkg::DIV_W-1:0] divisor,
  output tdpt_pkg::div_status_t      status
);
  import tdpt_pkg::*;

  logic [WIDTH-1:0] shreg;
  logic [DIV_W-1:0] dvsr;
  logic [DIV_W-1:0] rem;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   diff;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  assign shifted = {rem, shreg[WIDTH-1]};
  assign diff    = shifted - {1'b0, dvsr};

  assign status.busy     = busy;
  assign status.done     = done;
  assign status.rem_zero = (rem == '0);

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dvsr  <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[WIDTH-2:0], 1'b0};
      if (!diff[DIV_W]) begin
        rem <= diff[DIV_W-1:0];
      end else begin
        rem <= shifted[DIV_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[hw/rtl/tdpt_back.sv]
// Division engine: step odd divisors, hold the result beat
`timescale 1ns / 1ps
`include "trial_division_prime_test_defines.svh"
module tdpt_back (
  input  logic                   clk,
  input  logic                   rst,
  input  tdpt_pkg::queue_entry_t entry,
  input  logic                   empty,
  output logic                   pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [tdpt_pkg::OUT_W-1:0] m_tdata  // [0] is_prime, [1] is_even
);
  import tdpt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_DIV   = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [WIDTH-1:0] v;
  logic [DIV_W-1:0] d;
  logic [SQ_W-1:0]  sq;
  logic             res_prime;
  logic             res_even;
  logic             div_start;
  logic             out_free;
  div_status_t      div_status;

  tdpt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (v),
    .divisor  (d),
    .status   (div_status)
  );

  assign out_free  = !m_tvalid || m_tready;
  assign pop       = (state == S_IDLE) && !empty;
  assign div_start = (state == S_CHECK) && !(sq > {2'b00, v});

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (!empty) begin
          state_next = entry.trivial ? S_OUT : S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = div_start ? S_DIV : S_OUT;
      end
      S_DIV: begin
        if (div_status.done) begin
          state_next = div_status.rem_zero ? S_OUT : S_CHECK;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      v         <= entry.value;
      d         <= FIRST_DIV;
      sq        <= FIRST_SQ;
      res_prime <= entry.trivial_prime;
      res_even  <= !entry.value[0];
    end else if (state == S_CHECK && !div_start) begin
      res_prime <= 1'b1;
    end else if (state == S_DIV && div_status.done) begin
      if (div_status.rem_zero) begin
        res_prime <= 1'b0;
      end else begin
        d  <= d + DIV_STEP;
        sq <= sq + SQ_W'({d, 2'b00}) + SQ_STEP_ADD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      m_tdata <= {{(OUT_W - 2){1'b0}}, res_even, res_prime};
    end
  end

  `TDPT_ASSERT_IMPLIES(a_done_in_div, clk, rst, div_status.done, state == S_DIV)
  `TDPT_ASSERT_IMPLIES(a_odd_divisor, clk, rst, state == S_CHECK, d[0] && !div_status.busy)
  `TDPT_ASSERT_IMPLIES(a_square_track, clk, rst, state == S_CHECK, sq == SQ_W'(d * d))
  `TDPT_ASSERT_NEXT(a_start_busy, clk, rst, div_start, div_status.busy && state == S_DIV)
endmodule

[hw/rtl/trial_division_prime_test.sv]
// Top level of the trial division prime test block
//
//  channel  dir  beat contents
//  s_*      in   tdata[15:0] value
//  m_*      out  tdata[0] is_prime, tdata[1] is_even, tdata[7:2] zero
//
// Values below two and even values skip division and go from the queue to the output state.
// Odd values are tried by the bit-serial remainder unit against each odd divisor from 3
// up to the square root, one divisor at a time.
// A four-beat queue lets s_* keep accepting while the engine works or m_* stalls.
// Reset is synchronous and empties the queue and engine; no clearing pass.
`timescale 1ns / 1ps
module trial_division_prime_test (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [tdpt_pkg::IN_W-1:0]   s_tdata,  // [15:0] value
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [tdpt_pkg::OUT_W-1:0]  m_tdata   // [0] is_prime, [1] is_even
);
  import tdpt_pkg::*;

  queue_entry_t wr_entry;
  queue_entry_t rd_entry;
  logic         push;
  logic         pop;
  logic         full;
  logic         empty;

  tdpt_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .full     (full),
    .push     (push),
    .entry    (wr_entry)
  );

  tdpt_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (rd_entry),
    .full     (full),
    .empty    (empty)
  );

  tdpt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .entry    (rd_entry),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );
endmodule

[tb/tb.sv]
// Testbench for trial_division_prime_test: directed and random values checked against a predictor
`timescale 1ns / 1ps
module tb;
  import tdpt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 60;
  localparam int PHASE_ITEMS    = 36;
  localparam int BURST_ITEMS    = 12;
  localparam int DIRECTED_ROWS  = 16;

  typedef struct packed {
    logic [IN_W-1:0] value;
    logic            is_prime;
    logic            is_even;
  } flags_t;

  typedef struct packed {
    logic [IN_W-1:0] value;
    logic            typed;
    logic            is_prime;
    logic            is_even;
  } directed_row_t;

  typedef enum int {
    PICK_UNIFORM,
    PICK_SMALL,
    PICK_LARGE_PRIME,
    PICK_PRIME_SQUARE,
    PICK_EVEN
  } pick_kind_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  flags_t        awaited_flags[$];
  directed_row_t directed_rows[DIRECTED_ROWS];
  int            mismatch_count = 0;
  int            quiet_cycles = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  bit            hold_request = 1'b0;

  trial_division_prime_test i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [15:0] value
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // [0] is_prime, [1] is_even
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit value_is_prime(input logic [IN_W-1:0] raw);
    longint unsigned v;
    longint unsigned d;
    v = raw & ((64'd1 << WIDTH) - 1);
    if (v < 2) return 1'b0;
    for (d = 2; d * d <= v; d++) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic flags_t classify_value(input logic [IN_W-1:0] value);
    flags_t f;
    f.value    = value;
    f.is_prime = value_is_prime(value);
    f.is_even  = ~value[0];
    return f;
  endfunction

  function automatic logic [IN_W-1:0] pick_value(input pick_kind_t kind);
    int unsigned x;
    int unsigned p;
    x = 0;
    case (kind)
      PICK_UNIFORM: begin
        x = $urandom_range(65535, 0);
      end
      PICK_SMALL: begin
        x = $urandom_range(400, 0);
      end
      PICK_LARGE_PRIME: begin
        x = $urandom_range(65535, 30000) | 1;
        while (!value_is_prime(x[IN_W-1:0])) x = x - 2;
      end
      PICK_PRIME_SQUARE: begin
        p = $urandom_range(255, 3);
        while (!value_is_prime(p[IN_W-1:0])) p = p - 1;
        x = p * p;
      end
      default: begin
        x = $urandom_range(65535, 0) & ~32'd1;
      end
    endcase
    return x[IN_W-1:0];
  endfunction

  task automatic offer_value(input logic [IN_W-1:0] value, input logic typed,
                             input logic typed_prime, input logic typed_even);
    flags_t f;
    @(negedge clk);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    f = classify_value(value);
    if (typed) begin
      f.is_prime = typed_prime;
      f.is_even  = typed_even;
    end
    awaited_flags.insert(awaited_flags.size(), f);
  endtask

  task automatic offer_random(input int count);
    for (int i = 0; i < count; i++) begin
      offer_value(pick_value(pick_kind_t'($urandom_range(4, 0))), 1'b0, 1'b0, 1'b0);
    end
  endtask

  task automatic check_flags(input logic [OUT_W-1:0] beat);
    flags_t f;
    if (awaited_flags.size() == 0) begin
      $display("%0t: unexpected beat, expected none, actual %h", $time, beat);
      mismatch_count++;
    end else begin
      f = awaited_flags.pop_front();
      if (beat[0] !== f.is_prime) begin
        $display("%0t: value %0d is_prime expected %b actual %b",
                 $time, f.value, f.is_prime, beat[0]);
        mismatch_count++;
      end
      if (beat[1] !== f.is_even) begin
        $display("%0t: value %0d is_even expected %b actual %b",
                 $time, f.value, f.is_even, beat[1]);
        mismatch_count++;
      end
      if (beat[OUT_W-1:2] !== '0) begin
        $display("%0t: value %0d padding expected 0 actual %h",
                 $time, f.value, beat[OUT_W-1:2]);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_flags(m_tdata);
  end

  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    directed_rows = '{
      '{16'd0,     1'b1, 1'b0, 1'b1},
      '{16'd1,     1'b1, 1'b0, 1'b0},
      '{16'd2,     1'b1, 1'b1, 1'b1},
      '{16'd3,     1'b1, 1'b1, 1'b0},
      '{16'd4,     1'b1, 1'b0, 1'b1},
      '{16'd9,     1'b1, 1'b0, 1'b0},
      '{16'd25,    1'b0, 1'b0, 1'b0},
      '{16'd63001, 1'b1, 1'b0, 1'b0},
      '{16'd65521, 1'b1, 1'b1, 1'b0},
      '{16'd65535, 1'b1, 1'b0, 1'b0},
      '{16'd65534, 1'b1, 1'b0, 1'b1},
      '{16'd32768, 1'b0, 1'b0, 1'b0},
      '{16'd32767, 1'b0, 1'b0, 1'b0},
      '{16'h5555,  1'b0, 1'b0, 1'b0},
      '{16'hAAAA,  1'b0, 1'b0, 1'b0},
      '{16'd65519, 1'b0, 1'b0, 1'b0}
    };
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 6;
    recv_idle_pct = 58;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      offer_value(directed_rows[i].value, directed_rows[i].typed,
                  directed_rows[i].is_prime, directed_rows[i].is_even);
    end
    offer_random(PHASE_ITEMS);

    send_idle_pct = 58;
    recv_idle_pct = 6;
    offer_random(PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1'b1;
    for (int i = 0; i < BURST_ITEMS; i++) begin
      offer_value(pick_value(($urandom_range(1, 0) != 0) ? PICK_EVEN : PICK_SMALL),
                  1'b0, 1'b0, 1'b0);
    end
    offer_random(PHASE_ITEMS);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (awaited_flags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/tdpt_pkg.sv
hw/rtl/tdpt_front.sv
hw/rtl/tdpt_fifo.sv
hw/rtl/tdpt_div.sv
hw/rtl/tdpt_back.sv
hw/rtl/trial_division_prime_test.sv
tb/tb.sv
